// ----- rtl/core/rpbss_pkg.sv -----
// ----------------------------------------------------------------------------
// rpbss_pkg
// Shared types and constants for the best short-side fit rectangle packer.
// ----------------------------------------------------------------------------
package rpbss_pkg;

    localparam int FREE_DEPTH  = 64;
    localparam int IDX_W       = $clog2(FREE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_BITS  = 13;
    localparam int PAD_W       = 4;
    localparam int OUT_COORD_W = 12;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD     = 2'd2;

    localparam logic CMD_CLEAR = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } box_t;

    typedef enum logic [2:0] {
        ST_PLACED   = 3'd0,
        ST_NO_FIT   = 3'd1,
        ST_CLEARED  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_SCAN_RD,
        OP_SCAN_EVAL,
        OP_USED_RD,
        OP_USED_EVAL,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_REMOVE,
        OP_APP_R,
        OP_APP_T,
        OP_MERGE_INIT,
        OP_MA_RD,
        OP_MA_LOAD,
        OP_MB_RD,
        OP_MB_EVAL,
        OP_MA_WB,
        OP_MC_INIT,
        OP_MC_RD,
        OP_MC_WR,
        OP_MC_DONE,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t res;
    } dp_cmd_t;

    typedef struct packed {
        logic is_clear;
        logic empty_req;
        logic found;
        logic i_at_cnt;
        logic j_at_cnt;
        logic shift_done;
        logic a_empty;
        logic overflow;
        logic keep_r;
        logic keep_t;
        logic out_busy;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_EVAL,
        S_USED_RD,
        S_USED_EVAL,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_REMOVE,
        S_APP_R,
        S_APP_T,
        S_MINIT,
        S_MA_RD,
        S_MA_LOAD,
        S_MB_RD,
        S_MB_EVAL,
        S_MA_WB,
        S_MC_INIT,
        S_MC_RD,
        S_MC_WR,
        S_MC_DONE,
        S_RESULT
    } ctrl_state_t;

endpackage

// ----- rtl/core/rect_pack_best_short_side_unit.sv -----
// ----------------------------------------------------------------------------
// rect_pack_best_short_side_unit
// Guillotine rectangle packer with best short-side fit over a 64-entry list.
// ----------------------------------------------------------------------------
//  channel  | direction | beat contents
//  s_*      | in        | tuser: cmd; tdata: rect_width[12:0], rect_height[25:13]
//  m_*      | out       | tuser: status; tdata: place_x[11:0], place_y[23:12]
//  cfg_*    | in        | cfg_index: register, cfg_data: value
//
//  One beat at a time. Clear and empty requests skip the list; a no-fit scan
//  grows linearly and a placement quadratically with the n list entries,
//  set by the single read port of the free-list memory (each entry is read,
//  then used) and the quadratic merge pass.
//  Reset empties the list; nothing fits until a clear. No clearing pass.
//  A result waits in the output register; the next beat may enter meanwhile.
// ----------------------------------------------------------------------------
module rect_pack_best_short_side_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [31:0]                          s_tdata,   // rect_width, rect_height
    input  logic [0:0]                           s_tuser,   // cmd
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata,   // place_x, place_y
    output logic [2:0]                           m_tuser,   // status
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rpbss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpbss_pkg::COORD_BITS-1:0]     cfg_data
);

    localparam int CW = rpbss_pkg::COORD_BITS;
    localparam int OW = rpbss_pkg::OUT_COORD_W;

    rpbss_pkg::dp_cmd_t  cmd;
    rpbss_pkg::dp_stat_t stat;
    rpbss_pkg::status_t  out_status;
    logic [OW-1:0]       out_x, out_y;

    assign cfg_ready = 1'b1;

    rpbss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rpbss_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_cmd     (s_tuser[0]),
        .in_w       (s_tdata[CW-1:0]),
        .in_h       (s_tdata[2*CW-1:CW]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_x      (out_x),
        .out_y      (out_y)
    );

    assign m_tdata = {out_y, out_x};
    assign m_tuser = out_status;

endmodule

// ----- rtl/core/rpbss_dp.sv -----
// ----------------------------------------------------------------------------
// rpbss_dp
// Datapath: free-rectangle memory, scan/merge/compact arithmetic, counters,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module rpbss_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rpbss_pkg::dp_cmd_t                    cmd,
    output rpbss_pkg::dp_stat_t                   stat,
    input  logic                                  in_cmd,
    input  rpbss_pkg::coord_t                     in_w,
    input  rpbss_pkg::coord_t                     in_h,
    input  logic                                  cfg_we,
    input  logic [rpbss_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [rpbss_pkg::COORD_BITS-1:0]      cfg_wdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output rpbss_pkg::status_t                    out_status,
    output logic [rpbss_pkg::OUT_COORD_W-1:0]     out_x,
    output logic [rpbss_pkg::OUT_COORD_W-1:0]     out_y
);

    localparam int CW = rpbss_pkg::COORD_BITS;
    localparam int NW = rpbss_pkg::CNT_W;
    localparam int AW = rpbss_pkg::IDX_W;

    rpbss_pkg::box_t mem [rpbss_pkg::FREE_DEPTH];
    rpbss_pkg::box_t rdata_reg;

    rpbss_pkg::coord_t aw_reg, ah_reg;
    logic [rpbss_pkg::PAD_W-1:0] pad_cfg_reg, pad_reg;

    logic              cmd_reg;
    rpbss_pkg::coord_t rw_reg, rh_reg;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [NW-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [AW-1:0]     best_reg, best_next;
    rpbss_pkg::coord_t score_reg, score_next;
    logic              found_reg, found_next;
    rpbss_pkg::box_t   used_reg, used_next, right_reg, right_next, top_reg, top_next;
    logic              keep_r_reg, keep_r_next, keep_t_reg, keep_t_next;
    rpbss_pkg::box_t   a_reg, a_next;

    logic              out_valid_reg;
    rpbss_pkg::status_t out_status_reg;
    logic [rpbss_pkg::OUT_COORD_W-1:0] out_x_reg, out_y_reg;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    rpbss_pkg::box_t   wdata;
    logic [NW-1:0]     i_inc;

    // scan
    logic              fit;
    rpbss_pkg::coord_t dw, dh, score;
    // remainders
    logic [CW+1:0]     rem_w, rem_h, rx_sum, ty_sum;
    // merge
    rpbss_pkg::box_t   b, b_next;
    logic [CW:0]       a_top, b_top, a_rgt, b_rgt;
    logic              vert, horz, b_emp;
    logic [CW:0]       hsum, wsum;

    assign i_inc = i_reg + NW'(1);

    always_comb
    begin
        fit   = (rdata_reg.w >= rw_reg) && (rdata_reg.h >= rh_reg);
        dw    = rdata_reg.w - rw_reg;
        dh    = rdata_reg.h - rh_reg;
        score = (dh < dw) ? dh : dw;

        rem_w  = {2'b00, rdata_reg.w} - {2'b00, rw_reg} - (CW+2)'(pad_reg);
        rem_h  = {2'b00, rdata_reg.h} - {2'b00, rh_reg} - (CW+2)'(pad_reg);
        rx_sum = {2'b00, rdata_reg.x} + {2'b00, rw_reg} + (CW+2)'(pad_reg);
        ty_sum = {2'b00, rdata_reg.y} + {2'b00, rh_reg} + (CW+2)'(pad_reg);
    end

    always_comb
    begin
        b      = rdata_reg;
        a_top  = {1'b0, a_reg.y} + {1'b0, a_reg.h};
        b_top  = {1'b0, b.y} + {1'b0, b.h};
        a_rgt  = {1'b0, a_reg.x} + {1'b0, a_reg.w};
        b_rgt  = {1'b0, b.x} + {1'b0, b.w};
        hsum   = {1'b0, a_reg.h} + {1'b0, b.h};
        wsum   = {1'b0, a_reg.w} + {1'b0, b.w};
        b_emp  = (b.w == '0) || (b.h == '0);
        vert   = (a_reg.x == b.x) && (a_reg.w == b.w) &&
                 ((a_top == {1'b0, b.y}) || (b_top == {1'b0, a_reg.y}));
        horz   = (a_reg.y == b.y) && (a_reg.h == b.h) &&
                 ((a_rgt == {1'b0, b.x}) || (b_rgt == {1'b0, a_reg.x}));
        a_next = a_reg;
        b_next = b;
        if (!b_emp)
        begin
            if (vert)
            begin
                if (a_reg.y < b.y)
                begin
                    a_next.h = hsum[CW-1:0];
                    b_next.w = '0;
                end
                else
                begin
                    b_next.h = hsum[CW-1:0];
                    a_next.w = '0;
                end
            end
            else if (horz)
            begin
                if (a_reg.x < b.x)
                begin
                    a_next.w = wsum[CW-1:0];
                    b_next.h = '0;
                end
                else
                begin
                    b_next.w = wsum[CW-1:0];
                    a_next.h = '0;
                end
            end
        end
    end

    always_comb
    begin
        we          = 1'b0;
        waddr       = '0;
        wdata       = rdata_reg;
        raddr       = i_reg[AW-1:0];
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        best_next   = best_reg;
        score_next  = score_reg;
        found_next  = found_reg;
        used_next   = used_reg;
        right_next  = right_reg;
        top_next    = top_reg;
        keep_r_next = keep_r_reg;
        keep_t_next = keep_t_reg;
        unique case (cmd.op)
            rpbss_pkg::OP_LOAD:
            begin
                i_next     = '0;
                found_next = 1'b0;
            end
            rpbss_pkg::OP_CLEAR:
            begin
                wdata    = '{x: '0, y: '0, w: aw_reg, h: ah_reg};
                waddr    = '0;
                we       = (aw_reg != '0) && (ah_reg != '0);
                cnt_next = we ? NW'(1) : '0;
            end
            rpbss_pkg::OP_SCAN_EVAL:
            begin
                if (fit && (!found_reg || (score < score_reg)))
                begin
                    found_next = 1'b1;
                    score_next = score;
                    best_next  = i_reg[AW-1:0];
                end
                i_next = i_inc;
            end
            rpbss_pkg::OP_USED_RD:
            begin
                raddr = best_reg;
            end
            rpbss_pkg::OP_USED_EVAL:
            begin
                used_next   = rdata_reg;
                right_next  = '{x: rx_sum[CW-1:0], y: rdata_reg.y,
                                w: rem_w[CW-1:0], h: rh_reg};
                top_next    = '{x: rdata_reg.x, y: ty_sum[CW-1:0],
                                w: rdata_reg.w, h: rem_h[CW-1:0]};
                keep_r_next = !rem_w[CW+1] && (rem_w != '0);
                keep_t_next = !rem_h[CW+1] && (rem_h != '0);
                i_next      = {1'b0, best_reg};
            end
            rpbss_pkg::OP_SHIFT_RD:
            begin
                raddr = i_inc[AW-1:0];
            end
            rpbss_pkg::OP_SHIFT_WR:
            begin
                we     = 1'b1;
                waddr  = i_reg[AW-1:0];
                i_next = i_inc;
            end
            rpbss_pkg::OP_REMOVE:
            begin
                cnt_next = cnt_reg - NW'(1);
            end
            rpbss_pkg::OP_APP_R:
            begin
                we       = 1'b1;
                waddr    = cnt_reg[AW-1:0];
                wdata    = right_reg;
                cnt_next = cnt_reg + NW'(1);
            end
            rpbss_pkg::OP_APP_T:
            begin
                we       = 1'b1;
                waddr    = cnt_reg[AW-1:0];
                wdata    = top_reg;
                cnt_next = cnt_reg + NW'(1);
            end
            rpbss_pkg::OP_MERGE_INIT,
            rpbss_pkg::OP_MC_INIT:
            begin
                i_next = '0;
                k_next = '0;
            end
            rpbss_pkg::OP_MA_LOAD:
            begin
                j_next = i_inc;
            end
            rpbss_pkg::OP_MB_RD:
            begin
                raddr = j_reg[AW-1:0];
            end
            rpbss_pkg::OP_MB_EVAL:
            begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = b_next;
                j_next = j_reg + NW'(1);
            end
            rpbss_pkg::OP_MA_WB:
            begin
                we     = 1'b1;
                waddr  = i_reg[AW-1:0];
                wdata  = a_reg;
                i_next = i_inc;
            end
            rpbss_pkg::OP_MC_WR:
            begin
                we     = !b_emp;
                waddr  = k_reg[AW-1:0];
                k_next = b_emp ? k_reg : k_reg + NW'(1);
                i_next = i_inc;
            end
            rpbss_pkg::OP_MC_DONE:
            begin
                cnt_next = k_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aw_reg        <= CW'(1024);
            ah_reg        <= CW'(1024);
            pad_cfg_reg   <= '0;
            cnt_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == rpbss_pkg::CFG_ATLAS_W)
                begin
                    aw_reg <= cfg_wdata;
                end
                if (cfg_idx == rpbss_pkg::CFG_ATLAS_H)
                begin
                    ah_reg <= cfg_wdata;
                end
                if (cfg_idx == rpbss_pkg::CFG_PAD)
                begin
                    pad_cfg_reg <= cfg_wdata[rpbss_pkg::PAD_W-1:0];
                end
            end
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            found_reg <= found_next;
            if (cmd.op == rpbss_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        score_reg  <= score_next;
        used_reg   <= used_next;
        right_reg  <= right_next;
        top_reg    <= top_next;
        keep_r_reg <= keep_r_next;
        keep_t_reg <= keep_t_next;
        if (cmd.op == rpbss_pkg::OP_MA_LOAD)
        begin
            a_reg <= rdata_reg;
        end
        else if (cmd.op == rpbss_pkg::OP_MB_EVAL)
        begin
            a_reg <= a_next;
        end
        if (cmd.op == rpbss_pkg::OP_LOAD)
        begin
            cmd_reg <= in_cmd;
            rw_reg  <= in_w;
            rh_reg  <= in_h;
            pad_reg <= pad_cfg_reg;
        end
        if (cmd.op == rpbss_pkg::OP_RESULT)
        begin
            out_status_reg <= cmd.res;
            out_x_reg <= (cmd.res == rpbss_pkg::ST_PLACED) ?
                         used_reg.x[rpbss_pkg::OUT_COORD_W-1:0] : '0;
            out_y_reg <= (cmd.res == rpbss_pkg::ST_PLACED) ?
                         used_reg.y[rpbss_pkg::OUT_COORD_W-1:0] : '0;
        end
    end

    always_comb
    begin
        stat.is_clear   = (cmd_reg == rpbss_pkg::CMD_CLEAR);
        stat.empty_req  = (rw_reg == '0) || (rh_reg == '0);
        stat.found      = found_reg;
        stat.i_at_cnt   = (i_reg == cnt_reg);
        stat.j_at_cnt   = (j_reg == cnt_reg);
        stat.shift_done = (i_inc == cnt_reg);
        stat.a_empty    = (a_reg.w == '0) || (a_reg.h == '0);
        stat.overflow   = (cnt_reg == NW'(rpbss_pkg::FREE_DEPTH)) && keep_r_reg && keep_t_reg;
        stat.keep_r     = keep_r_reg;
        stat.keep_t     = keep_t_reg;
        stat.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;

endmodule

// ----- rtl/core/rpbss_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpbss_ctrl
// Sequencer: steps the datapath through scan, removal, append, merge and
// compaction, and issues one result per accepted beat.
// ----------------------------------------------------------------------------
module rpbss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output rpbss_pkg::dp_cmd_t   cmd,
    input  rpbss_pkg::dp_stat_t  stat
);

    rpbss_pkg::ctrl_state_t state_reg, state_next;
    rpbss_pkg::status_t     res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpbss_pkg::S_IDLE;
            res_reg   <= rpbss_pkg::ST_PLACED;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.op     = rpbss_pkg::OP_NONE;
        cmd.res    = res_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            rpbss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = rpbss_pkg::OP_LOAD;
                    state_next = rpbss_pkg::S_DISPATCH;
                end
            end
            rpbss_pkg::S_DISPATCH:
            begin
                if (stat.is_clear)
                begin
                    cmd.op     = rpbss_pkg::OP_CLEAR;
                    res_next   = rpbss_pkg::ST_CLEARED;
                    state_next = rpbss_pkg::S_RESULT;
                end
                else if (stat.empty_req)
                begin
                    res_next   = rpbss_pkg::ST_EMPTY;
                    state_next = rpbss_pkg::S_RESULT;
                end
                else
                begin
                    state_next = rpbss_pkg::S_SCAN_RD;
                end
            end
            rpbss_pkg::S_SCAN_RD:
            begin
                if (stat.i_at_cnt)
                begin
                    if (stat.found)
                    begin
                        state_next = rpbss_pkg::S_USED_RD;
                    end
                    else
                    begin
                        res_next   = rpbss_pkg::ST_NO_FIT;
                        state_next = rpbss_pkg::S_RESULT;
                    end
                end
                else
                begin
                    cmd.op     = rpbss_pkg::OP_SCAN_RD;
                    state_next = rpbss_pkg::S_SCAN_EVAL;
                end
            end
            rpbss_pkg::S_SCAN_EVAL:
            begin
                cmd.op     = rpbss_pkg::OP_SCAN_EVAL;
                state_next = rpbss_pkg::S_SCAN_RD;
            end
            rpbss_pkg::S_USED_RD:
            begin
                cmd.op     = rpbss_pkg::OP_USED_RD;
                state_next = rpbss_pkg::S_USED_EVAL;
            end
            rpbss_pkg::S_USED_EVAL:
            begin
                cmd.op     = rpbss_pkg::OP_USED_EVAL;
                state_next = rpbss_pkg::S_CHECK;
            end
            rpbss_pkg::S_CHECK:
            begin
                if (stat.overflow)
                begin
                    res_next   = rpbss_pkg::ST_OVERFLOW;
                    state_next = rpbss_pkg::S_RESULT;
                end
                else
                begin
                    state_next = rpbss_pkg::S_SHIFT_RD;
                end
            end
            rpbss_pkg::S_SHIFT_RD:
            begin
                if (stat.shift_done)
                begin
                    state_next = rpbss_pkg::S_REMOVE;
                end
                else
                begin
                    cmd.op     = rpbss_pkg::OP_SHIFT_RD;
                    state_next = rpbss_pkg::S_SHIFT_WR;
                end
            end
            rpbss_pkg::S_SHIFT_WR:
            begin
                cmd.op     = rpbss_pkg::OP_SHIFT_WR;
                state_next = rpbss_pkg::S_SHIFT_RD;
            end
            rpbss_pkg::S_REMOVE:
            begin
                cmd.op     = rpbss_pkg::OP_REMOVE;
                state_next = rpbss_pkg::S_APP_R;
            end
            rpbss_pkg::S_APP_R:
            begin
                if (stat.keep_r)
                begin
                    cmd.op = rpbss_pkg::OP_APP_R;
                end
                state_next = rpbss_pkg::S_APP_T;
            end
            rpbss_pkg::S_APP_T:
            begin
                if (stat.keep_t)
                begin
                    cmd.op = rpbss_pkg::OP_APP_T;
                end
                state_next = rpbss_pkg::S_MINIT;
            end
            rpbss_pkg::S_MINIT:
            begin
                cmd.op     = rpbss_pkg::OP_MERGE_INIT;
                state_next = rpbss_pkg::S_MA_RD;
            end
            rpbss_pkg::S_MA_RD:
            begin
                if (stat.i_at_cnt)
                begin
                    state_next = rpbss_pkg::S_MC_INIT;
                end
                else
                begin
                    cmd.op     = rpbss_pkg::OP_MA_RD;
                    state_next = rpbss_pkg::S_MA_LOAD;
                end
            end
            rpbss_pkg::S_MA_LOAD:
            begin
                cmd.op     = rpbss_pkg::OP_MA_LOAD;
                state_next = rpbss_pkg::S_MB_RD;
            end
            rpbss_pkg::S_MB_RD:
            begin
                // inner pass ends at list end or once the outer entry is merged away
                if (stat.j_at_cnt || stat.a_empty)
                begin
                    state_next = rpbss_pkg::S_MA_WB;
                end
                else
                begin
                    cmd.op     = rpbss_pkg::OP_MB_RD;
                    state_next = rpbss_pkg::S_MB_EVAL;
                end
            end
            rpbss_pkg::S_MB_EVAL:
            begin
                cmd.op     = rpbss_pkg::OP_MB_EVAL;
                state_next = rpbss_pkg::S_MB_RD;
            end
            rpbss_pkg::S_MA_WB:
            begin
                cmd.op     = rpbss_pkg::OP_MA_WB;
                state_next = rpbss_pkg::S_MA_RD;
            end
            rpbss_pkg::S_MC_INIT:
            begin
                cmd.op     = rpbss_pkg::OP_MC_INIT;
                state_next = rpbss_pkg::S_MC_RD;
            end
            rpbss_pkg::S_MC_RD:
            begin
                if (stat.i_at_cnt)
                begin
                    state_next = rpbss_pkg::S_MC_DONE;
                end
                else
                begin
                    cmd.op     = rpbss_pkg::OP_MC_RD;
                    state_next = rpbss_pkg::S_MC_WR;
                end
            end
            rpbss_pkg::S_MC_WR:
            begin
                cmd.op     = rpbss_pkg::OP_MC_WR;
                state_next = rpbss_pkg::S_MC_RD;
            end
            rpbss_pkg::S_MC_DONE:
            begin
                cmd.op     = rpbss_pkg::OP_MC_DONE;
                res_next   = rpbss_pkg::ST_PLACED;
                state_next = rpbss_pkg::S_RESULT;
            end
            rpbss_pkg::S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = rpbss_pkg::OP_RESULT;
                    state_next = rpbss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rpbss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/rpbss_chk.sv -----
// ----------------------------------------------------------------------------
// rpbss_chk
// Port-level checks for the rectangle packer, bound to the top level.
// ----------------------------------------------------------------------------
module rpbss_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // one beat in flight: input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == rpbss_pkg::ST_PLACED) || (m_tuser == rpbss_pkg::ST_NO_FIT) ||
                     (m_tuser == rpbss_pkg::ST_CLEARED) || (m_tuser == rpbss_pkg::ST_OVERFLOW) ||
                     (m_tuser == rpbss_pkg::ST_EMPTY))
        else $error("bad status code");

    a_zero_unless_placed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != rpbss_pkg::ST_PLACED) |-> (m_tdata == '0))
        else $error("corner nonzero on non-placed result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind rect_pack_best_short_side_unit rpbss_chk u_rpbss_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the best short-side fit rectangle packer: drives
// clear/place beats and register writes, predicts each status and corner
// from a private free-list copy, and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb;
    import rpbss_pkg::*;

    localparam int WATCHDOG = 200000;

    typedef struct {
        status_t    st;
        logic [11:0] px;
        logic [11:0] py;
    } placement_t;

    class placement_board;
        int x[FREE_DEPTH];
        int y[FREE_DEPTH];
        int w[FREE_DEPTH];
        int h[FREE_DEPTH];
        int count;
        int atlas_w;
        int atlas_h;
        int pad;
        int errors;
        placement_t pending[$];

        function new();
            atlas_w = 1024;
            atlas_h = 1024;
            pad = 0;
            count = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_BITS-1:0] v);
            if (idx == CFG_ATLAS_W) atlas_w = v;
            else if (idx == CFG_ATLAS_H) atlas_h = v;
            else if (idx == CFG_PAD) pad = v[PAD_W-1:0];
        endfunction

        function void merge_list();
            int i, j, k;
            k = 0;
            for (i = 0; i < count; i++) begin
                if (w[i] <= 0 || h[i] <= 0) continue;
                for (j = i + 1; j < count && w[i] > 0 && h[i] > 0; j++) begin
                    if (w[j] <= 0 || h[j] <= 0) continue;
                    if (x[i] == x[j] && w[i] == w[j] &&
                        (y[i] + h[i] == y[j] || y[j] + h[j] == y[i])) begin
                        if (y[i] < y[j]) begin h[i] += h[j]; w[j] = 0; end
                        else begin h[j] += h[i]; w[i] = 0; end
                    end else if (y[i] == y[j] && h[i] == h[j] &&
                        (x[i] + w[i] == x[j] || x[j] + w[j] == x[i])) begin
                        if (x[i] < x[j]) begin w[i] += w[j]; h[j] = 0; end
                        else begin w[j] += w[i]; h[i] = 0; end
                    end
                end
            end
            for (i = 0; i < count; i++)
                if (w[i] > 0 && h[i] > 0) begin
                    x[k] = x[i]; y[k] = y[i]; w[k] = w[i]; h[k] = h[i];
                    k++;
                end
            count = k;
        endfunction

        function void note_input(logic cmd, int rw, int rh);
            placement_t r;
            int i, best, score, s, n, ux, uy, uw, uh;
            int rx, ry, rwd, rht, tx, ty, twd, tht;
            bit found, keep_r, keep_t;
            r.st = ST_PLACED; r.px = 0; r.py = 0;
            found = 0; best = 0; score = 0;
            if (cmd == CMD_CLEAR) begin
                count = 0;
                if (atlas_w > 0 && atlas_h > 0) begin
                    x[0] = 0; y[0] = 0; w[0] = atlas_w; h[0] = atlas_h;
                    count = 1;
                end
                r.st = ST_CLEARED;
            end else if (rw == 0 || rh == 0) begin
                r.st = ST_EMPTY;
            end else begin
                for (i = 0; i < count; i++) begin
                    if (w[i] < rw || h[i] < rh) continue;
                    s = w[i] - rw;
                    if (h[i] - rh < s) s = h[i] - rh;
                    if (!found || s < score) begin found = 1; score = s; best = i; end
                end
                if (!found) r.st = ST_NO_FIT;
                else begin
                    ux = x[best]; uy = y[best]; uw = w[best]; uh = h[best];
                    rx = ux + rw + pad; ry = uy; rwd = uw - rw - pad; rht = rh;
                    tx = ux; ty = uy + rh + pad; twd = uw; tht = uh - rh - pad;
                    keep_r = rwd > 0 && rht > 0;
                    keep_t = twd > 0 && tht > 0;
                    n = count - 1 + keep_r + keep_t;
                    if (n > FREE_DEPTH) r.st = ST_OVERFLOW;
                    else begin
                        for (i = best; i + 1 < count; i++) begin
                            x[i] = x[i+1]; y[i] = y[i+1]; w[i] = w[i+1]; h[i] = h[i+1];
                        end
                        count--;
                        if (keep_r) begin
                            x[count] = rx; y[count] = ry; w[count] = rwd; h[count] = rht;
                            count++;
                        end
                        if (keep_t) begin
                            x[count] = tx; y[count] = ty; w[count] = twd; h[count] = tht;
                            count++;
                        end
                        merge_list();
                        r.px = ux[11:0];
                        r.py = uy[11:0];
                    end
                end
            end
            pending = {pending, r};
        endfunction

        task automatic report(string what, int got, int want);
            $display("mismatch %s: got %0d want %0d", what, got, want);
            errors++;
        endtask

        task automatic check_result(logic [2:0] st, logic [23:0] d);
            placement_t e;
            if (pending.size() == 0) begin
                report("unexpected beat status", st, -1);
                return;
            end
            e = pending.pop_front();
            if (st != e.st) report("status", st, e.st);
            if (d[11:0] != e.px) report("place_x", d[11:0], e.px);
            if (d[23:12] != e.py) report("place_y", d[23:12], e.py);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [23:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_data = '0;

    placement_board board;
    int idle_cycles;
    int rx_hold = 0;

    rect_pack_best_short_side_unit u_top (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // always a nonzero idle gap so tvalid drops before the next beat
    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 1;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_item(logic cmd, int rw, int rh);
        int g;
        g = gap_len();
        repeat (g) @(posedge clk);
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {6'd0, rh[12:0], rw[12:0]};
        do @(posedge clk); while (!s_tready);
        board.note_input(cmd, rw & 13'h1fff, rh & 13'h1fff);
        s_tvalid <= 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v[COORD_BITS-1:0];
        do @(posedge clk); while (!cfg_ready);
        board.set_reg(idx, v[COORD_BITS-1:0]);
        cfg_valid <= 0;
    endtask

    // random size, mostly small, a few big or zero
    function automatic int pick_size(int lim);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 0;
        if (k == 1) return $urandom_range(0, 8191);
        if (k < 4) return $urandom_range(1, lim);
        return $urandom_range(1, (lim > 64) ? lim / 8 : lim);
    endfunction

    // receiver side with random stalls, now and then a long one
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                m_tready <= (rx_hold == 1);
            end else if (!m_tready || (m_tvalid && m_tready)) begin
                if ($urandom_range(0, 24) == 0) begin
                    rx_hold <= $urandom_range(20, 120);
                    m_tready <= 0;
                end else
                    m_tready <= ($urandom_range(0, 3) != 0);
            end else if ($urandom_range(0, 30) == 0) m_tready <= 0;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int i, phase, n;
        board = new();
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: before any clear nothing fits
        send_item(CMD_PLACE, 4, 4);
        send_item(CMD_CLEAR, 8191, 8191);
        send_item(CMD_PLACE, 0, 5);
        send_item(CMD_PLACE, 5, 0);
        send_item(CMD_PLACE, 2000, 1024);
        send_item(CMD_PLACE, 1025, 1);
        send_item(CMD_PLACE, 100, 100);
        send_item(CMD_PLACE, 100, 100);
        send_item(CMD_PLACE, 924, 1024);
        write_reg(CFG_ATLAS_W, 4096);
        write_reg(CFG_ATLAS_H, 8191);
        write_reg(CFG_PAD, 15);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_PLACE, 4096, 100);
        send_item(CMD_PLACE, 8191, 1);
        send_item(CMD_PLACE, 4095, 4095);
        send_item(CMD_PLACE, 1, 1);
        write_reg(CFG_ATLAS_W, 0);
        send_item(CMD_CLEAR, 3, 3);
        send_item(CMD_PLACE, 1, 1);
        write_reg(CFG_ATLAS_W, 1);
        write_reg(CFG_ATLAS_H, 1);
        write_reg(CFG_PAD, 0);
        send_item(CMD_CLEAR, 0, 0);
        send_item(CMD_PLACE, 1, 1);
        send_item(CMD_PLACE, 1, 1);

        // random phases: small atlases keep the list short
        for (phase = 0; phase < 9; phase++) begin
            case (phase % 3)
                0: begin
                    write_reg(CFG_ATLAS_W, $urandom_range(16, 256));
                    write_reg(CFG_ATLAS_H, $urandom_range(16, 256));
                end
                1: begin
                    write_reg(CFG_ATLAS_W, $urandom_range(1, 8191));
                    write_reg(CFG_ATLAS_H, $urandom_range(1, 8191));
                end
                default: begin
                    write_reg(CFG_ATLAS_W, 4096);
                    write_reg(CFG_ATLAS_H, $urandom_range(1, 64));
                end
            endcase
            write_reg(CFG_PAD, (phase == 8) ? 15 : $urandom_range(0, 15));
            send_item(CMD_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
            n = 25 + $urandom_range(0, 4);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 24) == 0)
                    send_item(CMD_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
                else
                    send_item(CMD_PLACE, pick_size(board.atlas_w > 0 ? board.atlas_w : 1),
                              pick_size(board.atlas_h > 0 ? board.atlas_h : 1));
            end
        end

        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- rect_pack_best_short_side_unit.f -----
rtl/core/rpbss_pkg.sv
rtl/core/rpbss_dp.sv
rtl/core/rpbss_ctrl.sv
rtl/core/rect_pack_best_short_side_unit.sv
rtl/core/rpbss_chk.sv
tb/sv/tb.sv
